@@ sv/ksa_pkg.sv @@
// ---------------------------------------------------------------------------
// ksa_pkg: shared types and constants of the kaleidoscope address core
// Widths, pipeline stage map, arctangent table and code names.
// ---------------------------------------------------------------------------
package ksa_pkg;

	localparam int MAX_DIM      = 4096;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = 5;
	localparam int DIM_W        = 13;
	localparam int CRD_W        = 12;
	localparam int OFS_W        = 26;
	localparam int BPP_W        = 3;
	localparam int SEG_W        = 7;
	localparam int CFG_W        = 13;
	localparam int XY_W         = 32;
	localparam int Z_W          = 34;
	localparam int DIV_BITS     = 31;
	localparam int REM_W        = 7;
	localparam int PROD_W       = 52;

	localparam logic [30:0] KINV      = 31'd652032874;
	localparam logic [31:0] HALF_PI_Z = 32'd1073741824;

	// stage map: index of the pipeline stage whose registers hold a beat
	localparam int ST_VEC_LAST  = CORDIC_STEPS;
	localparam int ST_POLAR     = ST_VEC_LAST + 1;
	localparam int ST_DIV_FIRST = ST_POLAR + 1;
	localparam int ST_DIV_LAST  = ST_POLAR + DIV_BITS;
	localparam int ST_ROT_SET   = ST_DIV_LAST + 1;
	localparam int ST_ROT_LAST  = ST_ROT_SET + CORDIC_STEPS;
	localparam int ST_CLAMP     = ST_ROT_LAST + 1;
	localparam int ST_SPROD     = ST_CLAMP + 1;
	localparam int ST_OUT       = ST_SPROD + 1;

	typedef logic signed [XY_W-1:0] xy_t;
	typedef logic signed [Z_W-1:0]  ang_t;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_BPP    = 2'd2,
		CFG_SEGS   = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		MODE_VECTOR = 1'b0,
		MODE_ROTATE = 1'b1
	} cordic_mode_t;

	// atan(2^-i), pi = 2^31
	function automatic ang_t atan_lut(input logic [STEP_W-1:0] idx);
		ang_t v;
		case (idx)
			5'd0:  v = 34'sd536870912;
			5'd1:  v = 34'sd316933405;
			5'd2:  v = 34'sd167458907;
			5'd3:  v = 34'sd85004756;
			5'd4:  v = 34'sd42667331;
			5'd5:  v = 34'sd21354465;
			5'd6:  v = 34'sd10679838;
			5'd7:  v = 34'sd5340245;
			5'd8:  v = 34'sd2670163;
			5'd9:  v = 34'sd1335086;
			5'd10: v = 34'sd667544;
			5'd11: v = 34'sd333772;
			5'd12: v = 34'sd166886;
			5'd13: v = 34'sd83443;
			5'd14: v = 34'sd41721;
			5'd15: v = 34'sd20860;
			5'd16: v = 34'sd10430;
			5'd17: v = 34'sd5215;
			5'd18: v = 34'sd2607;
			5'd19: v = 34'sd1303;
			5'd20: v = 34'sd651;
			5'd21: v = 34'sd325;
			5'd22: v = 34'sd162;
			5'd23: v = 34'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/ksa_coord_if.sv @@
// ---------------------------------------------------------------------------
// ksa_coord_if: output pixel coordinate channel
// One beat carries one destination pixel position.
// ---------------------------------------------------------------------------
interface ksa_coord_if;
	logic                      valid;
	logic                      ready;
	logic [ksa_pkg::CRD_W-1:0] out_x;
	logic [ksa_pkg::CRD_W-1:0] out_y;

	modport source (output valid, output out_x, output out_y, input ready);
	modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

@@ sv/ksa_addr_if.sv @@
// ---------------------------------------------------------------------------
// ksa_addr_if: source address channel
// One beat carries the source pixel and both byte offsets.
// ---------------------------------------------------------------------------
interface ksa_addr_if;
	logic                      valid;
	logic                      ready;
	logic [ksa_pkg::CRD_W-1:0] src_x;
	logic [ksa_pkg::CRD_W-1:0] src_y;
	logic [ksa_pkg::OFS_W-1:0] src_offset;
	logic [ksa_pkg::OFS_W-1:0] dst_offset;

	modport source (output valid, output src_x, output src_y, output src_offset,
		output dst_offset, input ready);
	modport sink   (input valid, input src_x, input src_y, input src_offset,
		input dst_offset, output ready);
endinterface

@@ sv/ksa_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// ksa_cordic_cell: one registered CORDIC micro-rotation
// Vectoring steers on the sign of y, rotation on the sign of z.
// ---------------------------------------------------------------------------
module ksa_cordic_cell (
	input  logic                       clk,
	input  logic                       en,
	input  ksa_pkg::cordic_mode_t      mode,
	input  logic [ksa_pkg::STEP_W-1:0] step,
	input  ksa_pkg::xy_t               x_in,
	input  ksa_pkg::xy_t               y_in,
	input  ksa_pkg::ang_t              z_in,
	output ksa_pkg::xy_t               x_out,
	output ksa_pkg::xy_t               y_out,
	output ksa_pkg::ang_t              z_out
);
	import ksa_pkg::*;

	xy_t  xs, ys, x_q, y_q;
	ang_t ang, z_q;
	logic up;

	assign xs  = x_in >>> step;
	assign ys  = y_in >>> step;
	assign ang = atan_lut(step);
	assign up  = (mode == MODE_VECTOR) ? !y_in[XY_W-1] : z_in[Z_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (up) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ang;
			end else begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ang;
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;
endmodule

@@ sv/ksa_div_cell.sv @@
// ---------------------------------------------------------------------------
// ksa_div_cell: one restoring division step
// Bring down the next dividend bit, subtract the divisor where it fits.
// ---------------------------------------------------------------------------
module ksa_div_cell (
	input  logic                         clk,
	input  logic                         en,
	input  logic [ksa_pkg::SEG_W-1:0]    divisor,
	input  logic [ksa_pkg::REM_W-1:0]    rem_in,
	input  logic [ksa_pkg::DIV_BITS-1:0] num_in,
	input  logic [ksa_pkg::DIV_BITS-1:0] quo_in,
	output logic [ksa_pkg::REM_W-1:0]    rem_out,
	output logic [ksa_pkg::DIV_BITS-1:0] num_out,
	output logic [ksa_pkg::DIV_BITS-1:0] quo_out
);
	import ksa_pkg::*;

	logic [REM_W:0]    trial, diff;
	logic              fits;
	logic [REM_W-1:0]  rem_q;
	logic [DIV_BITS-1:0] num_q, quo_q;

	assign trial = {rem_in, num_in[DIV_BITS-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
			num_q <= {num_in[DIV_BITS-2:0], 1'b0};
			quo_q <= {quo_in[DIV_BITS-2:0], fits};
		end
	end

	assign rem_out = rem_q;
	assign num_out = num_q;
	assign quo_out = quo_q;
endmodule

@@ sv/kaleidoscope_source_address_core.sv @@
// ---------------------------------------------------------------------------
// kaleidoscope_source_address_core: kaleidoscope remap address generator
// Polar conversion, segment mirroring and back-rotation of pixel positions.
// ---------------------------------------------------------------------------
// Usage:
//   coord  : one beat per destination pixel (out_x, out_y), accepted when
//            valid and ready are both high.
//   addr   : one beat per coordinate, in order: clamped source pixel, source
//            and destination byte offsets.
//   cfg_*  : register writes (width, height, bytes per pixel, segments),
//            taken at any edge with cfg_we high; write only while idle.
//   Throughput is one coordinate per cycle while the receiver takes results:
//   a chain of 16 vectoring cells, 31 divider cells and 16 rotation cells,
//   each one stage deep.
//   When the receiver stalls with a result waiting the whole chain holds
//   and coord.ready drops; it rises again the cycle the result is taken.
//   Reset clears all beat valid flags and loads 640x480, 3 bytes, 6 segments.
// ---------------------------------------------------------------------------
module kaleidoscope_source_address_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_idx,
	input  logic [ksa_pkg::CFG_W-1:0] cfg_data,
	ksa_coord_if.sink                 coord,
	ksa_addr_if.source                addr
);
	import ksa_pkg::*;

	localparam logic signed [PROD_W-1:0] KINV_S = PROD_W'(KINV);
	localparam logic signed [PROD_W-1:0] RND29  = PROD_W'(64'd536870912);
	localparam logic signed [PROD_W-1:0] RND17  = PROD_W'(64'd131072);
	localparam ang_t                     QTR_Z  = Z_W'(HALF_PI_Z);

	// configuration
	logic [DIM_W-1:0] width_q, height_q;
	logic [BPP_W-1:0] bpp_q;
	logic [SEG_W-1:0] segs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
			bpp_q    <= BPP_W'(3);
			segs_q   <= SEG_W'(6);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				CFG_BPP:    bpp_q    <= cfg_data[BPP_W-1:0];
				CFG_SEGS:   segs_q   <= cfg_data[SEG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp dimensions to 1..MAX_DIM, segments to at least one
	logic [DIM_W-1:0] w_eff, h_eff;
	logic [CRD_W-1:0] cx, cy;
	logic [SEG_W-1:0] n_eff;

	assign w_eff = (width_q == '0) ? DIM_W'(1) :
		(width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_q;
	assign h_eff = (height_q == '0) ? DIM_W'(1) :
		(height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_q;
	assign cx    = w_eff[DIM_W-1:1];
	assign cy    = h_eff[DIM_W-1:1];
	assign n_eff = (segs_q == '0) ? SEG_W'(1) : segs_q;

	// beat flags: the whole chain advances together unless a result is stuck
	logic vld_q [0:ST_OUT];
	logic en;

	assign en          = !vld_q[ST_OUT] || addr.ready;
	assign coord.ready = en;
	assign addr.valid  = vld_q[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= ST_OUT; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= coord.valid;
			for (int k = 1; k <= ST_OUT; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	// entry: centre offset with 4 fraction bits, fold the left half plane
	logic signed [13:0] dx, dy;
	logic signed [17:0] fx, fy;
	xy_t  ex, ey, vx0_c, vy0_c;
	ang_t vz0_c;
	logic [24:0] dpix_c;

	assign dx = signed'({2'b00, coord.out_x}) - signed'({2'b00, cx});
	assign dy = signed'({2'b00, coord.out_y}) - signed'({2'b00, cy});
	assign fx = {dx, 4'b0000};
	assign fy = {dy, 4'b0000};
	assign ex = XY_W'(fx);
	assign ey = XY_W'(fy);
	assign dpix_c = 25'(coord.out_y) * 25'(w_eff) + 25'(coord.out_x);

	always_comb begin
		vx0_c = ex;
		vy0_c = ey;
		vz0_c = '0;
		if (ex < 0) begin
			if (ey >= 0) begin
				vx0_c = ey;
				vy0_c = -ex;
				vz0_c = Z_W'(HALF_PI_Z);
			end else begin
				vx0_c = -ey;
				vy0_c = ex;
				vz0_c = -Z_W'(HALF_PI_Z);
			end
		end
	end

	xy_t  vx [0:CORDIC_STEPS];
	xy_t  vy [0:CORDIC_STEPS];
	ang_t vz [0:CORDIC_STEPS];
	logic [24:0]      dpix_q;
	logic [OFS_W-1:0] dst_q [1:ST_OUT];

	always_ff @(posedge clk) begin
		if (en) begin
			vx[0]  <= vx0_c;
			vy[0]  <= vy0_c;
			vz[0]  <= vz0_c;
			dpix_q <= dpix_c;
			dst_q[1] <= OFS_W'(dpix_q) * OFS_W'(bpp_q);
			for (int k = 2; k <= ST_OUT; k++) dst_q[k] <= dst_q[k-1];
		end
	end

	// vectoring chain
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
		ksa_cordic_cell u_cell (
			.clk   (clk),
			.en    (en),
			.mode  (MODE_VECTOR),
			.step  (STEP_W'(i)),
			.x_in  (vx[i]),
			.y_in  (vy[i]),
			.z_in  (vz[i]),
			.x_out (vx[i+1]),
			.y_out (vy[i+1]),
			.z_out (vz[i+1])
		);
	end

	// polar: scale radius, round angle, fold into one segment numerator
	logic signed [19:0]       xv;
	logic signed [PROD_W-1:0] r4_full;
	ang_t                     zr;
	logic signed [17:0]       a_c;
	logic [17:0]              a_abs;
	logic [15:0]              mag;
	logic [22:0]              mn;

	assign xv      = vx[CORDIC_STEPS][19:0];
	assign r4_full = (PROD_W'(xv) * KINV_S + RND29) >>> 30;
	assign zr      = (vz[CORDIC_STEPS] + Z_W'(32768)) >>> 16;
	assign a_c     = zr[17:0];
	assign a_abs   = a_c[17] ? 18'(-a_c) : 18'(a_c);
	assign mag     = (a_abs > 18'd32768) ? 16'd32768 : a_abs[15:0];
	assign mn      = 23'(mag) * 23'(n_eff);

	logic signed [19:0] r4_q;
	logic [14:0]        u_q;
	logic               neg_p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			r4_q    <= r4_full[19:0];
			u_q     <= mn[14:0];
			neg_p_q <= a_c[17];
		end
	end

	// divider chain: (u << 16) / segments, one quotient bit per cell
	logic [REM_W-1:0]    drem [0:DIV_BITS];
	logic [DIV_BITS-1:0] dnum [0:DIV_BITS];
	logic [DIV_BITS-1:0] dquo [0:DIV_BITS];

	assign drem[0] = '0;
	assign dnum[0] = {u_q, 16'h0000};
	assign dquo[0] = '0;

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		ksa_div_cell u_cell (
			.clk     (clk),
			.en      (en),
			.divisor (n_eff),
			.rem_in  (drem[k]),
			.num_in  (dnum[k]),
			.quo_in  (dquo[k]),
			.rem_out (drem[k+1]),
			.num_out (dnum[k+1]),
			.quo_out (dquo[k+1])
		);
	end

	// rotation start magnitude runs beside the divider
	logic signed [PROD_W-1:0] x0_full;
	xy_t  x0_q  [ST_DIV_FIRST:ST_DIV_LAST];
	logic neg_q [ST_DIV_FIRST:ST_DIV_LAST];

	assign x0_full = (PROD_W'(r4_q) * KINV_S + RND17) >>> 18;

	always_ff @(posedge clk) begin
		if (en) begin
			x0_q[ST_DIV_FIRST]  <= x0_full[XY_W-1:0];
			neg_q[ST_DIV_FIRST] <= neg_p_q;
			for (int k = ST_DIV_FIRST + 1; k <= ST_DIV_LAST; k++) begin
				x0_q[k]  <= x0_q[k-1];
				neg_q[k] <= neg_q[k-1];
			end
		end
	end

	// rotation setup: sign the mirrored angle, pre-rotate past a right angle
	ang_t m_c, rz0_c;
	xy_t  x0, rx0_c, ry0_c;

	assign x0  = x0_q[ST_DIV_LAST];
	assign m_c = neg_q[ST_DIV_LAST] ? -Z_W'(dquo[DIV_BITS]) : Z_W'(dquo[DIV_BITS]);

	always_comb begin
		rx0_c = x0;
		ry0_c = '0;
		rz0_c = m_c;
		if (m_c > QTR_Z) begin
			rx0_c = '0;
			ry0_c = x0;
			rz0_c = m_c - QTR_Z;
		end else if (m_c < -QTR_Z) begin
			rx0_c = '0;
			ry0_c = -x0;
			rz0_c = m_c + QTR_Z;
		end
	end

	xy_t  rx [0:CORDIC_STEPS];
	xy_t  ry [0:CORDIC_STEPS];
	ang_t rz [0:CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			rx[0] <= rx0_c;
			ry[0] <= ry0_c;
			rz[0] <= rz0_c;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		ksa_cordic_cell u_cell (
			.clk   (clk),
			.en    (en),
			.mode  (MODE_ROTATE),
			.step  (STEP_W'(i)),
			.x_in  (rx[i]),
			.y_in  (ry[i]),
			.z_in  (rz[i]),
			.x_out (rx[i+1]),
			.y_out (ry[i+1]),
			.z_out (rz[i+1])
		);
	end

	// back to pixels: floor, re-centre, clamp to the image
	logic signed [17:0] sxs, sys, wmax, hmax;
	logic [CRD_W-1:0]   sx_c, sy_c;

	assign sxs  = 18'(signed'(rx[CORDIC_STEPS][XY_W-1:16])) + signed'({6'd0, cx});
	assign sys  = 18'(signed'(ry[CORDIC_STEPS][XY_W-1:16])) + signed'({6'd0, cy});
	assign wmax = signed'({5'd0, w_eff}) - 18'sd1;
	assign hmax = signed'({5'd0, h_eff}) - 18'sd1;
	assign sx_c = (sxs < 0) ? '0 : (sxs > wmax) ? wmax[CRD_W-1:0] : sxs[CRD_W-1:0];
	assign sy_c = (sys < 0) ? '0 : (sys > hmax) ? hmax[CRD_W-1:0] : sys[CRD_W-1:0];

	logic [CRD_W-1:0] sx_s1, sy_s1, sx_s2, sy_s2, sx_s3, sy_s3;
	logic [24:0]      spix_s2;
	logic [OFS_W-1:0] soff_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1   <= sx_c;
			sy_s1   <= sy_c;
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			spix_s2 <= 25'(sy_s1) * 25'(w_eff) + 25'(sx_s1);
			sx_s3   <= sx_s2;
			sy_s3   <= sy_s2;
			soff_s3 <= OFS_W'(spix_s2) * OFS_W'(bpp_q);
		end
	end

	assign addr.src_x      = sx_s3;
	assign addr.src_y      = sy_s3;
	assign addr.src_offset = soff_s3;
	assign addr.dst_offset = dst_q[ST_OUT];

`ifndef SYNTHESIS
	a_hold_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_q[ST_POLAR]) && $stable(vld_q[ST_OUT])))
		else $error("beat flags moved while the chain was held");
	a_reach_out: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[ST_OUT-1]) |=> addr.valid)
		else $error("beat lost before the output register");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!addr.valid |-> coord.ready)
		else $error("input held back with no result waiting");
`endif

endmodule

@@ tb/kaleidoscope_source_address_core_tb.sv @@
// ---------------------------------------------------------------------------
// kaleidoscope_source_address_core_tb: self-checking bench for the remap core
// Drives pixel positions through the coordinate channel under several image
// settings and checks every source address beat against a bit-true predictor.
// ---------------------------------------------------------------------------
module kaleidoscope_source_address_core_tb;
	import ksa_pkg::*;

	typedef struct packed {
		logic [CRD_W-1:0] sx;
		logic [CRD_W-1:0] sy;
		logic [OFS_W-1:0] src_ofs;
		logic [OFS_W-1:0] dst_ofs;
	} src_addr_t;

	// atan(2^-i) with pi as 2^31, truncated
	localparam longint ATAN_Z [16] = '{
		536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335086, 667544, 333772,
		166886, 83443, 41721, 20860
	};
	localparam longint INV_GAIN = 652032874;
	localparam longint QUARTER  = 1073741824;
	localparam int     SETTLE   = 100;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	ksa_coord_if coord ();
	ksa_addr_if  addr ();

	kaleidoscope_source_address_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.coord   (coord.sink),
		.addr    (addr.source)
	);

	// shadow copy of the register file, as written
	logic [12:0] img_w;
	logic [12:0] img_h;
	logic [2:0]  pix_bytes;
	logic [6:0]  segments;

	src_addr_t pending_addr [$];
	int        errors;
	bit        steady;       // no random gaps on either side while set
	int        hold_request; // long receiver hold-off, in cycles

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15000000;
		$display("** kaleidoscope_source_address_core: FAILED **");
		$finish;
	end

	function automatic longint eff_dim(logic [12:0] d);
		if (d == 0)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return longint'(d);
	endfunction

	// Mirror one destination pixel into the first segment and map it back.
	function automatic src_addr_t predict_source(logic [CRD_W-1:0] px, logic [CRD_W-1:0] py);
		longint w, h, n, cx, cy, x, y, z, t, xs, ys, r4, a, mag, m, sx, sy;
		src_addr_t r;
		w  = eff_dim(img_w);
		h  = eff_dim(img_h);
		n  = (segments == 0) ? 1 : longint'(segments);
		cx = w / 2;
		cy = h / 2;
		x  = (longint'(px) - cx) * 16;
		y  = (longint'(py) - cy) * 16;
		z  = 0;
		// left half plane: turn by a quarter first
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = QUARTER;
			end else begin
				x = -y; y = t; z = -QUARTER;
			end
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + ATAN_Z[i];
			end else begin
				x = x - ys; y = y + xs; z = z - ATAN_Z[i];
			end
		end
		r4  = (x * INV_GAIN + (64'sd1 <<< 29)) >>> 30;
		a   = (z + 32768) >>> 16;
		mag = (a < 0) ? -a : a;
		if (mag > 32768)
			mag = 32768;
		m = (((mag * n) & 32767) <<< 16) / n;
		if (a < 0)
			m = -m;
		x = (r4 * INV_GAIN + (64'sd1 <<< 17)) >>> 18;
		y = 0;
		z = m;
		if (z > QUARTER) begin
			y = x; x = 0; z = z - QUARTER;
		end else if (z < -QUARTER) begin
			y = -x; x = 0; z = z + QUARTER;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - ATAN_Z[i];
			end else begin
				x = x + ys; y = y - xs; z = z + ATAN_Z[i];
			end
		end
		sx = cx + (x >>> 16);
		sy = cy + (y >>> 16);
		sx = (sx < 0) ? 0 : ((sx > w - 1) ? w - 1 : sx);
		sy = (sy < 0) ? 0 : ((sy > h - 1) ? h - 1 : sy);
		r.sx      = sx[CRD_W-1:0];
		r.sy      = sy[CRD_W-1:0];
		r.src_ofs = OFS_W'((sy * w + sx) * longint'(pix_bytes));
		r.dst_ofs = OFS_W'((longint'(py) * w + longint'(px)) * longint'(pix_bytes));
		return r;
	endfunction

	// mostly back-to-back or short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55)
			return 0;
		if (roll < 96)
			return $urandom_range(1, 4);
		return $urandom_range(20, 60);
	endfunction

	// Offer one coordinate beat and hold it until taken.
	task automatic send_coord(logic [CRD_W-1:0] px, logic [CRD_W-1:0] py);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			coord.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coord.valid <= 1'b1;
		coord.out_x <= px;
		coord.out_y <= py;
		@(posedge clk);
		while (!coord.ready)
			@(posedge clk);
		pending_addr.push_back(predict_source(px, py));
	endtask

	// Drop valid, let the pipe empty out and settle before touching registers.
	task automatic drain();
		coord.valid <= 1'b0;
		wait (pending_addr.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges; call only when drained.
	task automatic set_image(logic [12:0] w, logic [12:0] h, logic [2:0] b, logic [6:0] s);
		cfg_idx_t idx;
		logic [CFG_W-1:0] val;
		for (int i = 0; i < 4; i++) begin
			idx = cfg_idx_t'(i);
			case (idx)
				CFG_WIDTH:  val = w;
				CFG_HEIGHT: val = h;
				CFG_BPP:    val = CFG_W'(b);
				default:    val = CFG_W'(s);
			endcase
			cfg_we   <= 1'b1;
			cfg_idx  <= idx;
			cfg_data <= val;
			@(posedge clk);
			case (idx)
				CFG_WIDTH:  img_w = val;
				CFG_HEIGHT: img_h = val[12:0];
				CFG_BPP:    pix_bytes = val[2:0];
				default:    segments = val[6:0];
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	// Corners, centre, axes and far outside the image at reset settings.
	task automatic test_reset_geometry();
		send_coord(0, 0);
		send_coord(639, 479);
		send_coord(320, 240);
		send_coord(321, 240);
		send_coord(320, 0);
		send_coord(0, 240);
		send_coord(4095, 4095);
		send_coord(0, 4095);
		send_coord(4095, 0);
		send_coord(12'hAAA, 12'h555);
		drain();
	endtask

	// Degenerate and oversize register values, including the out-of-range ones.
	task automatic test_register_extremes();
		set_image(13'd1, 13'd1, 3'd0, 7'd1);
		send_coord(0, 0);
		send_coord(4095, 4095);
		drain();
		set_image(13'd4096, 13'd4096, 3'd4, 7'd64);
		send_coord(2048, 2048);
		send_coord(4095, 0);
		send_coord(0, 4095);
		send_coord(4095, 4095);
		drain();
		set_image(13'd0, 13'd0, 3'd7, 7'd0);
		send_coord(0, 0);
		send_coord(100, 3);
		drain();
		set_image(13'h1FFF, 13'd5000, 3'd7, 7'd127);
		send_coord(4095, 4095);
		send_coord(1, 2047);
		send_coord(2049, 3000);
		drain();
	endtask

	// Random settings per phase; mostly positions inside the image.
	task automatic test_random_frames();
		logic [12:0] w, h;
		logic [CRD_W-1:0] px, py;
		longint ew, eh;
		for (int phase = 0; phase < 6; phase++) begin
			if ($urandom_range(0, 3) == 0)
				w = 13'($urandom_range(0, 8191));
			else
				w = 13'($urandom_range(1, 4096));
			h = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 64))
			                                 : 13'($urandom_range(1, 4096));
			set_image(w, h, 3'($urandom_range(0, 7)),
			          ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
			                                      : 7'($urandom_range(1, 64)));
			steady = (phase == 2);
			ew = eff_dim(img_w);
			eh = eff_dim(img_h);
			for (int k = 0; k < 210; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					px = CRD_W'($urandom_range(0, 4095));
					py = CRD_W'($urandom_range(0, 4095));
				end else begin
					px = CRD_W'($urandom_range(0, int'(ew) - 1));
					py = CRD_W'($urandom_range(0, int'(eh) - 1));
				end
				send_coord(px, py);
			end
			steady = 1'b0;
			drain();
		end
	endtask

	// Hold the receiver off while offering back-to-back beats so the chain
	// fills and the coordinate channel stalls.
	task automatic test_backpressure();
		set_image(13'd640, 13'd480, 3'd3, 7'd6);
		steady = 1'b1;
		hold_request = 400;
		for (int k = 0; k < 150; k++)
			send_coord(CRD_W'($urandom_range(0, 639)), CRD_W'($urandom_range(0, 479)));
		steady = 1'b0;
		drain();
	endtask

	// Receiver: random holds, plus the long hold-off on request.
	initial begin : receiver
		int stall;
		stall = 0;
		addr.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end
			if (stall > 0) begin
				stall--;
				addr.ready <= 1'b0;
			end else begin
				addr.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	task automatic check_field(string name, logic [OFS_W-1:0] exp_v, logic [OFS_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Compare each taken address beat with the oldest prediction.
	always @(posedge clk) begin : addr_check
		src_addr_t want;
		if (arst_n && addr.valid && addr.ready) begin
			if (pending_addr.size() == 0) begin
				$display("%0t: unexpected address beat, expected none, actual %0d/%0d",
				         $realtime, addr.src_x, addr.src_y);
				errors++;
			end else begin
				want = pending_addr.pop_front();
				check_field("src_x", OFS_W'(want.sx), OFS_W'(addr.src_x));
				check_field("src_y", OFS_W'(want.sy), OFS_W'(addr.src_y));
				check_field("src_offset", want.src_ofs, addr.src_offset);
				check_field("dst_offset", want.dst_ofs, addr.dst_offset);
			end
		end
	end

	initial begin
		errors       = 0;
		steady       = 1'b0;
		hold_request = 0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = CFG_WIDTH;
		cfg_data     = '0;
		coord.valid  = 1'b0;
		coord.out_x  = '0;
		coord.out_y  = '0;
		img_w        = 13'd640;
		img_h        = 13'd480;
		pix_bytes    = 3'd3;
		segments     = 7'd6;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_register_extremes();
		test_random_frames();
		test_backpressure();

		if (errors == 0)
			$display("** kaleidoscope_source_address_core: PASSED **");
		else
			$display("** kaleidoscope_source_address_core: FAILED **");
		$finish;
	end

endmodule
